/* src/ssrr_pkg.sv */
`timescale 1ns / 1ps

package ssrr_pkg;

   // Index space and list depth
   localparam int unsigned IDX_W       = 6;
   localparam int unsigned CNT_W       = 7;
   localparam int unsigned IDX_SPACE   = 64;
   localparam logic [CNT_W-1:0] MAX_MEMBERS = 7'd64;
   localparam logic [CNT_W-1:0] NO_ROUND    = 7'd127;
   localparam logic [CNT_W-1:0] SIZE_RESET  = 7'd64;

   // Request kinds carried on tuser
   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_SCAN  = 2'd2;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_DONE     = 3'd0,
      STAT_NOCHANGE = 3'd1,
      STAT_RANGE    = 3'd2,
      STAT_FULL     = 3'd3,
      STAT_EMPTY    = 3'd4
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_DECIDE,
      S_MOVE,
      S_WRAP,
      S_SCAN_RD,
      S_SCAN_OUT,
      S_RESP
   } state_type;

   // Modulo unit request and reply
   typedef struct packed {
      logic             start;
      logic [CNT_W-1:0] numer;
      logic [CNT_W-1:0] denom;
   } mod_req_type;

   typedef struct packed {
      logic             done;
      logic [CNT_W-1:0] remainder;
   } mod_rsp_type;

endpackage

/* src/sparse_set_round_robin_scan.sv */
`timescale 1ns / 1ps

// Sparse set of indices 0..63 with a round-robin member scan. One request is
// taken at a time; req_tready is high only while the sequencer is idle. A set
// or clear runs a position lookup, then decide and write, plus a move step
// when a clear moves the last list member into the hole, and then loads the
// result register. A scan passes the decide step, waits for the iterative
// modulo unit whenever it advances the rotating start (every scan except the
// first after reset or after a scan of an empty set), reads the first member,
// and then delivers one member per cycle while rsp_tready is high. Membership
// lives in per-index valid bits cleared by reset, so no clearing pass is run.
// csr_wr_data sets the number of accepted index values (reset 64); write it
// only while the block is idle.
module sparse_set_round_robin_scan (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data,   // active_size
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,     // [5:0] bit_index, [7:6] zero
   input  logic [1:0]  req_tuser,     // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,     // [5:0] member_index, [8:6] status, [15:9] member_count
   output logic        rsp_tlast      // last_result
);
   import ssrr_pkg::*;

   state_type        state_ff, state_in;
   logic [1:0]       mode_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] rot_ff, rot_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   status_type       stat_ff, stat_in;
   logic [CNT_W-1:0] active_size_ff;
   logic [CNT_W-1:0] limit;

   // Position map and member list storage
   logic [IDX_SPACE-1:0] pv_ff;
   logic [CNT_W-1:0]     pm_mem [IDX_SPACE];
   logic [CNT_W-1:0]     pm_q_ff;
   logic [IDX_W-1:0]     ml_mem [IDX_SPACE];
   logic [IDX_W-1:0]     ml_q_ff;

   logic             pm_rd_en, pm_wr_en, pv_clr;
   logic [IDX_W-1:0] pm_rd_addr, pm_wr_addr;
   logic [CNT_W-1:0] pm_wr_data, pm_cur;
   logic             ml_rd_en, ml_wr_en;
   logic [IDX_W-1:0] ml_rd_addr, ml_wr_addr, ml_wr_data;
   logic [CNT_W-1:0] next_pos;

   logic             out_free, out_load, out_last;
   logic [IDX_W-1:0] out_member;
   status_type       out_status;
   logic             rsp_tvalid_ff;
   logic [15:0]      rsp_tdata_ff;
   logic             rsp_tlast_ff;

   mod_req_type mod_req;
   mod_rsp_type mod_rsp;

   ssrr_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .mod_req (mod_req),
      .mod_rsp (mod_rsp)
   );

   assign limit    = (active_size_ff > MAX_MEMBERS) ? MAX_MEMBERS : active_size_ff;
   assign pm_cur   = pv_ff[idx_ff] ? pm_q_ff : '0;
   assign out_free = !rsp_tvalid_ff || rsp_tready;
   assign next_pos = ({1'b0, pos_ff} + 7'd1 == cnt_ff) ? '0 : {1'b0, pos_ff} + 7'd1;

   // Next state and datapath control
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      rot_in     = rot_ff;
      pos_in     = pos_ff;
      rem_in     = rem_ff;
      stat_in    = stat_ff;
      req_tready = 1'b0;
      pm_rd_en   = 1'b0;
      pm_rd_addr = req_tdata[IDX_W-1:0];
      pm_wr_en   = 1'b0;
      pm_wr_addr = idx_ff;
      pm_wr_data = cnt_ff + 7'd1;
      pv_clr     = 1'b0;
      ml_rd_en   = 1'b0;
      ml_rd_addr = pos_ff;
      ml_wr_en   = 1'b0;
      ml_wr_addr = cnt_ff[IDX_W-1:0];
      ml_wr_data = idx_ff;
      mod_req    = '{start: 1'b0, numer: rot_ff + 7'd1, denom: cnt_ff};
      out_load   = 1'b0;
      out_member = '0;
      out_status = stat_ff;
      out_last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               pm_rd_en = 1'b1;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            state_in = S_RESP;
            case (mode_ff)
               MODE_SET: begin
                  priority if ({1'b0, idx_ff} >= limit) begin
                     stat_in = STAT_RANGE;
                  end else if (cnt_ff >= limit) begin
                     stat_in = STAT_FULL;
                  end else if (pm_cur != '0) begin
                     stat_in = STAT_NOCHANGE;
                  end else begin
                     // Append at the tail of the list
                     ml_wr_en = 1'b1;
                     pm_wr_en = 1'b1;
                     cnt_in   = cnt_ff + 7'd1;
                     stat_in  = STAT_DONE;
                  end
               end
               MODE_CLEAR: begin
                  priority if ({1'b0, idx_ff} >= limit) begin
                     stat_in = STAT_RANGE;
                  end else if (cnt_ff == '0) begin
                     stat_in = STAT_EMPTY;
                  end else if (pm_cur == '0) begin
                     stat_in = STAT_NOCHANGE;
                  end else begin
                     // Drop the member; fetch the tail if it must fill the hole
                     pv_clr  = 1'b1;
                     cnt_in  = cnt_ff - 7'd1;
                     pos_in  = IDX_W'(pm_cur - 7'd1);
                     stat_in = STAT_DONE;
                     if (pm_cur < cnt_ff) begin
                        ml_rd_en   = 1'b1;
                        ml_rd_addr = IDX_W'(cnt_ff - 7'd1);
                        state_in   = S_MOVE;
                     end
                  end
               end
               MODE_SCAN: begin
                  priority if (cnt_ff == '0) begin
                     rot_in  = NO_ROUND;
                     stat_in = STAT_EMPTY;
                  end else if (rot_ff == NO_ROUND) begin
                     rot_in   = '0;
                     pos_in   = '0;
                     rem_in   = cnt_ff;
                     state_in = S_SCAN_RD;
                  end else begin
                     mod_req.start = 1'b1;
                     rem_in        = cnt_ff;
                     state_in      = S_WRAP;
                  end
               end
               default: begin
                  stat_in = STAT_NOCHANGE;
               end
            endcase
         end
         S_MOVE: begin
            // Move the tail member into the hole
            pm_wr_en   = 1'b1;
            pm_wr_addr = ml_q_ff;
            pm_wr_data = {1'b0, pos_ff} + 7'd1;
            ml_wr_en   = 1'b1;
            ml_wr_addr = pos_ff;
            ml_wr_data = ml_q_ff;
            state_in   = S_RESP;
         end
         S_WRAP: begin
            if (mod_rsp.done) begin
               rot_in   = mod_rsp.remainder;
               pos_in   = IDX_W'(mod_rsp.remainder);
               state_in = S_SCAN_RD;
            end
         end
         S_SCAN_RD: begin
            ml_rd_en = 1'b1;
            state_in = S_SCAN_OUT;
         end
         S_SCAN_OUT: begin
            // Emit one member a cycle while the output is free and prefetch the next
            out_member = ml_q_ff;
            out_status = STAT_DONE;
            out_last   = (rem_ff == 7'd1);
            if (out_free) begin
               out_load = 1'b1;
               rem_in   = rem_ff - 7'd1;
               pos_in   = next_pos[IDX_W-1:0];
               if (rem_ff == 7'd1) begin
                  state_in = S_IDLE;
               end else begin
                  ml_rd_en   = 1'b1;
                  ml_rd_addr = next_pos[IDX_W-1:0];
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cnt_ff         <= '0;
         rot_ff         <= NO_ROUND;
         active_size_ff <= SIZE_RESET;
         pv_ff          <= '0;
         rsp_tvalid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         rot_ff   <= rot_in;
         if (csr_wr_en) begin
            active_size_ff <= csr_wr_data;
         end
         if (pm_wr_en) begin
            pv_ff[pm_wr_addr] <= 1'b1;
         end
         if (pv_clr) begin
            pv_ff[idx_ff] <= 1'b0;
         end
         if (out_load) begin
            rsp_tvalid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid_ff <= 1'b0;
         end
      end
   end

   // Working registers and result beat
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff <= req_tuser;
         idx_ff  <= req_tdata[IDX_W-1:0];
      end
      pos_ff  <= pos_in;
      rem_ff  <= rem_in;
      stat_ff <= stat_in;
      if (out_load) begin
         rsp_tdata_ff <= {cnt_ff, out_status, out_member};
         rsp_tlast_ff <= out_last;
      end
   end

   // Position map memory
   always_ff @(posedge clock) begin
      if (pm_wr_en) begin
         pm_mem[pm_wr_addr] <= pm_wr_data;
      end
      if (pm_rd_en) begin
         pm_q_ff <= pm_mem[pm_rd_addr];
      end
   end

   // Member list memory
   always_ff @(posedge clock) begin
      if (ml_wr_en) begin
         ml_mem[ml_wr_addr] <= ml_wr_data;
      end
      if (ml_rd_en) begin
         ml_q_ff <= ml_mem[ml_rd_addr];
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

/* src/ssrr_mod_unit.sv */
`timescale 1ns / 1ps

// Restoring remainder, one shifted compare and subtract per cycle.
module ssrr_mod_unit (
   input  logic                clock,
   input  logic                reset,
   input  ssrr_pkg::mod_req_type mod_req,
   output ssrr_pkg::mod_rsp_type mod_rsp
);
   import ssrr_pkg::*;

   logic [CNT_W-1:0] r_ff, r_in;
   logic [CNT_W-1:0] d_ff;
   logic [2:0]       k_ff;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [12:0]      sub_val;
   logic             ge;

   // Divisor shifted to the current quotient bit
   assign sub_val = {6'b0, d_ff} << k_ff;
   assign ge      = {6'b0, r_ff} >= sub_val;

   // Step the remainder
   always_comb begin
      r_in    = r_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (busy_ff) begin
         if (ge) begin
            r_in = r_ff - sub_val[CNT_W-1:0];
         end
         if (k_ff == 3'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= mod_req.start ? 1'b1 : busy_in;
         done_ff <= mod_req.start ? 1'b0 : done_in;
      end
   end

   // Operand registers
   always_ff @(posedge clock) begin
      if (mod_req.start) begin
         r_ff <= mod_req.numer;
         d_ff <= mod_req.denom;
         k_ff <= 3'd6;
      end else begin
         r_ff <= r_in;
         if (busy_ff && k_ff != 3'd0) begin
            k_ff <= k_ff - 3'd1;
         end
      end
   end

   assign mod_rsp.done      = done_ff;
   assign mod_rsp.remainder = r_ff;

endmodule

/* src/ssrr_checker.sv */
`timescale 1ns / 1ps

module ssrr_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   import ssrr_pkg::*;

   // Hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result beat changed while stalled");

   // One request at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   // Only scan members precede the last beat
   a_scan_beats_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[8:6] == STAT_DONE)
      else $error("non-final beat with status other than done");

   // Beats other than done carry no member and end the run
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8:6] != STAT_DONE |-> rsp_tlast && rsp_tdata[5:0] == 6'd0)
      else $error("status beat with member or not last");

   // Count never exceeds the list depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:9] <= MAX_MEMBERS)
      else $error("member count out of bounds");

endmodule

bind sparse_set_round_robin_scan ssrr_checker u_ssrr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
